FILE: rtl/tqfn_pkg.sv
// Shared types and constants of the face normal core.
`default_nettype none

package tqfn_pkg;

    localparam int IDX_W       = 12;
    localparam int CRD_W       = 24;
    localparam int NRM_W       = 16;
    localparam int KIND_W      = 2;
    localparam int SQ_W        = 30;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CELL  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_QUAD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ZERO  = 2'd1,
        OP_TRI   = 2'd2,
        OP_QUAD  = 2'd3
    } t_op;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic [IDX_W-1:0]        index_d;
        logic signed [CRD_W-1:0] coord_x;
        logic signed [CRD_W-1:0] coord_y;
        logic signed [CRD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    degenerate;
    } t_out_item;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic [IDX_W-1:0]        index_d;
        logic signed [CRD_W-1:0] coord_x;
        logic signed [CRD_W-1:0] coord_y;
        logic signed [CRD_W-1:0] coord_z;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

FILE: rtl/triangle_quad_face_normal_core.sv
// Top level of the face normal core: front end, item queue and back end.
//
// Input channel: i_in_valid / o_in_stall carry one t_in_item. A write item
// (command 0) stores one vertex at index_a and returns nothing. A cell item
// (command 1) returns one t_out_item with the unit normal of the cell named by
// its indices, using the cell kind register (point and line kinds give zero).
// Output channel: o_out_valid / i_out_stall carry one t_out_item.
// Configuration: i_cfg_we writes i_cfg_wdata into the cell kind register.
// Throughput is one item per cycle while the receiver does not stall: four
// copies of the vertex store give the four corner reads of a cell together,
// and all arithmetic is pipelined. Most of the pipeline lies in the two
// normalizers with their square root and division pipelines.
// Reset empties the queue and the pipeline and sets the cell kind to
// triangle; the vertex store holds no defined data until written.
// While the receiver stalls, the whole back end holds, the four-entry queue
// fills, and then o_in_stall rises.
`default_nettype none

module triangle_quad_face_normal_core import tqfn_pkg::*; #(
    parameter int VERTEX_COUNT     = 4096,
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [KIND_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    logic      w_push;
    logic      w_pop;
    t_q_entry  w_entry;
    t_q_entry  w_head;
    t_q_status w_q_status;

    tqfn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_q_status  (w_q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    tqfn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    tqfn_back #(
        .VERTEX_COUNT     (VERTEX_COUNT),
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/tqfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tqfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/tqfn_front.sv
// Front end: cell kind register, item classification and queue push.
`default_nettype none

module tqfn_front import tqfn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [KIND_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    input  t_q_status         i_q_status,
    output logic              o_in_stall,
    output logic              o_push,
    output t_q_entry          o_entry
);

    t_kind r_kind;
    t_op   w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_TRI;
        end else if (i_cfg_we) begin
            r_kind <= t_kind'(i_cfg_wdata);
        end
    end

    always_comb begin
        if (i_in_item.command == CMD_WRITE) begin
            w_op = OP_WRITE;
        end else begin
            unique case (r_kind)
                KIND_TRI:              w_op = OP_TRI;
                KIND_QUAD:             w_op = OP_QUAD;
                KIND_POINT, KIND_LINE: w_op = OP_ZERO;
            endcase
        end
    end

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    assign o_entry.op      = w_op;
    assign o_entry.index_a = i_in_item.index_a;
    assign o_entry.index_b = i_in_item.index_b;
    assign o_entry.index_c = i_in_item.index_c;
    assign o_entry.index_d = i_in_item.index_d;
    assign o_entry.coord_x = i_in_item.coord_x;
    assign o_entry.coord_y = i_in_item.coord_y;
    assign o_entry.coord_z = i_in_item.coord_z;

endmodule

`default_nettype wire

FILE: rtl/tqfn_queue.sv
// Short register queue between the front end and the back end.
`default_nettype none

module tqfn_queue import tqfn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + {{QPTR_W{1'b0}}, i_push} - {{QPTR_W{1'b0}}, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/tqfn_norm.sv
// Pipelined vector normalizer: scale, square root and per-component division.
`default_nettype none

module tqfn_norm import tqfn_pkg::*; #(
    parameter int W  = 51,
    parameter int F  = 14,
    parameter int TW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic signed [W-1:0] i_v [3],
    input  logic [TW-1:0]       i_tag,
    output logic signed [F+1:0] o_n [3],
    output logic                o_degen,
    output logic [TW-1:0]       o_tag
);

    localparam int NC  = (W + 7) / 8;
    localparam int LW  = $clog2(W + 1);
    localparam int SQN = SQ_W + 1;
    localparam int NNW = 2 * SQN;
    localparam int RW  = SQN + 1;
    localparam int NMW = SQ_W + F + 1;
    localparam int DVN = F + 1;
    localparam int LAT = 6 + SQN + 1 + DVN + 1;

    logic [TW-1:0] r_tag [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_tag[i] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign o_tag = r_tag[LAT-1];

    logic [W-1:0]      r1_m [3];
    logic              r1_neg [3];
    logic [W-1:0]      r1_or;
    logic [W-1:0]      w_raw [3];
    logic [W-1:0]      w_m [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_raw[c] = i_v[c];
            w_m[c]   = w_raw[c][W-1] ? (~w_raw[c] + 1'b1) : w_raw[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_m[c]   <= w_m[c];
                r1_neg[c] <= w_raw[c][W-1];
            end
            r1_or <= w_m[0] | w_m[1] | w_m[2];
        end
    end

    logic [NC*8-1:0] w_pad;
    logic            w_nz [NC];
    logic [3:0]      w_cl [NC];
    logic            r2_nz [NC];
    logic [3:0]      r2_cl [NC];
    logic [W-1:0]    r2_m [3];
    logic            r2_neg [3];

    always_comb begin
        w_pad = (NC*8)'(r1_or);
        for (int ch = 0; ch < NC; ch++) begin
            w_nz[ch] = |w_pad[ch*8 +: 8];
            w_cl[ch] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_pad[ch*8+b]) begin
                    w_cl[ch] = 4'(b + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < NC; ch++) begin
                r2_nz[ch] <= w_nz[ch];
                r2_cl[ch] <= w_cl[ch];
            end
            r2_m   <= r1_m;
            r2_neg <= r1_neg;
        end
    end

    logic [LW-1:0] w_len;
    logic [LW-1:0] r3_len;
    logic [W-1:0]  r3_m [3];
    logic          r3_neg [3];

    always_comb begin
        w_len = '0;
        for (int ch = 0; ch < NC; ch++) begin
            if (r2_nz[ch]) begin
                w_len = LW'(ch * 8) + LW'(r2_cl[ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_len <= w_len;
            r3_m   <= r2_m;
            r3_neg <= r2_neg;
        end
    end

    logic [W+SQ_W-1:0] w_ext [3];
    logic [W+SQ_W-1:0] w_sh [3];
    logic [SQ_W-1:0]   r4_s [3];
    logic              r4_neg [3];
    logic              r4_deg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ext[c] = {r3_m[c], {SQ_W{1'b0}}};
            w_sh[c]  = w_ext[c] >> r3_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r4_s[c] <= w_sh[c][SQ_W-1:0];
            end
            r4_neg <= r3_neg;
            r4_deg <= (r3_len == '0);
        end
    end

    logic [2*SQ_W-1:0] r5_sq [3];
    logic [SQ_W-1:0]   r5_s [3];
    logic              r5_neg [3];
    logic              r5_deg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r5_sq[c] <= r4_s[c] * r4_s[c];
            end
            r5_s   <= r4_s;
            r5_neg <= r4_neg;
            r5_deg <= r4_deg;
        end
    end

    logic [NNW-1:0]  r_sn    [SQN+1];
    logic [RW-1:0]   r_srem  [SQN+1];
    logic [SQN-1:0]  r_sroot [SQN+1];
    logic [SQ_W-1:0] r_ss    [SQN+1][3];
    logic            r_sneg  [SQN+1][3];
    logic            r_sdeg  [SQN+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn[0]    <= NNW'(r5_sq[0]) + NNW'(r5_sq[1]) + NNW'(r5_sq[2]);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_ss[0]    <= r5_s;
            r_sneg[0]  <= r5_neg;
            r_sdeg[0]  <= r5_deg;
        end
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [RW+1:0] w_cur;
        logic [RW+1:0] w_try;
        logic          w_ge;

        assign w_cur = {r_srem[k], r_sn[k][NNW-1 -: 2]};
        assign w_try = (RW+2)'({r_sroot[k], 2'b01});
        assign w_ge  = (w_cur >= w_try);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[k+1]  <= w_ge ? RW'(w_cur - w_try) : RW'(w_cur);
                r_sroot[k+1] <= {r_sroot[k][SQN-2:0], w_ge};
                r_sn[k+1]    <= r_sn[k] << 2;
                r_ss[k+1]    <= r_ss[k];
                r_sneg[k+1]  <= r_sneg[k];
                r_sdeg[k+1]  <= r_sdeg[k];
            end
        end
    end

    logic [NMW-1:0] w_num  [3];
    logic [RW-1:0]  r_drem [DVN+1][3];
    logic [F:0]     r_dlow [DVN+1][3];
    logic [F:0]     r_dq   [DVN+1][3];
    logic [SQN-1:0] r_dl   [DVN+1];
    logic           r_dneg [DVN+1][3];
    logic           r_ddeg [DVN+1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_num[c] = NMW'({r_ss[SQN][c], {F{1'b0}}}) + NMW'(r_sroot[SQN] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_drem[0][c] <= RW'(w_num[c][NMW-1 -: SQ_W]);
                r_dlow[0][c] <= w_num[c][F:0];
                r_dq[0][c]   <= '0;
            end
            r_dl[0]   <= r_sroot[SQN];
            r_dneg[0] <= r_sneg[SQN];
            r_ddeg[0] <= r_sdeg[SQN];
        end
    end

    for (genvar k = 0; k < DVN; k++) begin : g_div
        logic [RW:0] w_cur [3];
        logic        w_ge  [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_cur[c] = {r_drem[k][c], r_dlow[k][c][F]};
                w_ge[c]  = (w_cur[c] >= (RW+1)'(r_dl[k]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_drem[k+1][c] <= w_ge[c] ? RW'(w_cur[c] - (RW+1)'(r_dl[k]))
                                              : RW'(w_cur[c]);
                    r_dq[k+1][c]   <= {r_dq[k][c][F-1:0], w_ge[c]};
                    r_dlow[k+1][c] <= r_dlow[k][c] << 1;
                end
                r_dl[k+1]   <= r_dl[k];
                r_dneg[k+1] <= r_dneg[k];
                r_ddeg[k+1] <= r_ddeg[k];
            end
        end
    end

    logic signed [F+1:0] w_q [3];
    logic signed [F+1:0] r_out [3];
    logic                r_deg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_q[c] = {1'b0, r_dq[DVN][c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_ddeg[DVN]) begin
                    r_out[c] <= '0;
                end else if (r_dneg[DVN][c]) begin
                    r_out[c] <= -w_q[c];
                end else begin
                    r_out[c] <= w_q[c];
                end
            end
            r_deg <= r_ddeg[DVN];
        end
    end

    assign o_n     = r_out;
    assign o_degen = r_deg;

endmodule

`default_nettype wire

FILE: rtl/tqfn_back.sv
// Back end: vertex store, cross products, normalization and result register.
`default_nettype none

module tqfn_back import tqfn_pkg::*; #(
    parameter int VERTEX_COUNT     = 4096,
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_entry  i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int AW  = $clog2(VERTEX_COUNT);
    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int NW  = F + 2;
    localparam int SW  = F + 4;
    localparam int OW  = (NW > NRM_W) ? NW : NRM_W;
    localparam int T1W = 3;
    localparam int T2W = 1 + 2 + 1 + 3 * NW;

    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_adv;

    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = w_adv && !i_q_status.empty;

    logic [IDX_W-1:0] w_idx  [4];
    logic [AW-1:0]    w_addr [4];
    logic             w_inr  [4];

    assign w_idx[0] = i_head.index_a;
    assign w_idx[1] = i_head.index_b;
    assign w_idx[2] = i_head.index_c;
    assign w_idx[3] = i_head.index_d;

    for (genvar k = 0; k < 4; k++) begin : g_addr
        logic [AW+IDX_W-1:0] w_ext;
        assign w_ext     = {{AW{1'b0}}, w_idx[k]};
        assign w_addr[k] = w_ext[AW-1:0];
        assign w_inr[k]  = (w_ext < (AW+IDX_W)'(VERTEX_COUNT));
    end

    logic signed [31:0] w_c32 [3];
    logic [3*CW-1:0]    w_wdata;
    logic               w_we;
    logic [3*CW-1:0]    w_rdata [4];

    assign w_c32[0] = 32'(i_head.coord_x);
    assign w_c32[1] = 32'(i_head.coord_y);
    assign w_c32[2] = 32'(i_head.coord_z);
    assign w_wdata  = {w_c32[0][CW-1:0], w_c32[1][CW-1:0], w_c32[2][CW-1:0]};
    assign w_we     = o_pop && (i_head.op == OP_WRITE) && w_inr[0];

    for (genvar k = 0; k < 4; k++) begin : g_store
        tqfn_ram #(
            .WIDTH(3 * CW),
            .DEPTH(VERTEX_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_addr[0]),
            .i_wdata (w_wdata),
            .i_re    (w_adv),
            .i_raddr (w_addr[k]),
            .o_rdata (w_rdata[k])
        );
    end

    logic r0_valid;
    t_op  r0_op;
    logic r0_inr [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_op  <= i_q_status.empty ? OP_WRITE : i_head.op;
            r0_inr <= w_inr;
        end
    end

    logic signed [CW-1:0] w_v [4][3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k][0] = w_rdata[k][3*CW-1 -: CW];
            w_v[k][1] = w_rdata[k][2*CW-1 -: CW];
            w_v[k][2] = w_rdata[k][CW-1:0];
            if (!r0_inr[k]) begin
                for (int c = 0; c < 3; c++) begin
                    w_v[k][c] = '0;
                end
            end
        end
    end

    logic                 r1_valid;
    t_op                  r1_op;
    logic signed [DW-1:0] r1_u [4][3];
    logic signed [DW-1:0] r1_w [4][3];
    logic                 r2_valid;
    t_op                  r2_op;
    logic signed [PW-1:0] r2_p [4][6];
    logic                 r3_valid;
    t_op                  r3_op;
    logic signed [XW-1:0] r3_x [4][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    for (genvar t = 0; t < 4; t++) begin : g_tri
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int c = 0; c < 3; c++) begin
                    r1_u[t][c] <= DW'(w_v[(t+1)%4][c]) - DW'(w_v[t][c]);
                    r1_w[t][c] <= DW'(w_v[(t+2)%4][c]) - DW'(w_v[t][c]);
                end
                r2_p[t][0] <= r1_u[t][1] * r1_w[t][2];
                r2_p[t][1] <= r1_u[t][2] * r1_w[t][1];
                r2_p[t][2] <= r1_u[t][2] * r1_w[t][0];
                r2_p[t][3] <= r1_u[t][0] * r1_w[t][2];
                r2_p[t][4] <= r1_u[t][0] * r1_w[t][1];
                r2_p[t][5] <= r1_u[t][1] * r1_w[t][0];
                r3_x[t][0] <= XW'(r2_p[t][0]) - XW'(r2_p[t][1]);
                r3_x[t][1] <= XW'(r2_p[t][2]) - XW'(r2_p[t][3]);
                r3_x[t][2] <= XW'(r2_p[t][4]) - XW'(r2_p[t][5]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op <= r0_op;
            r2_op <= r1_op;
            r3_op <= r2_op;
        end
    end

    logic signed [NW-1:0] w_n1 [4][3];
    logic                 w_deg1 [4];
    logic [T1W-1:0]       w_tag1;

    tqfn_norm #(
        .W  (XW),
        .F  (F),
        .TW (T1W)
    ) u_norm_tri0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r3_x[0]),
        .i_tag   ({r3_valid, r3_op}),
        .o_n     (w_n1[0]),
        .o_degen (w_deg1[0]),
        .o_tag   (w_tag1)
    );

    for (genvar t = 1; t < 4; t++) begin : g_norm
        tqfn_norm #(
            .W  (XW),
            .F  (F),
            .TW (1)
        ) u_norm_tri (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_v     (r3_x[t]),
            .i_tag   (1'b0),
            .o_n     (w_n1[t]),
            .o_degen (w_deg1[t]),
            .o_tag   ()
        );
    end

    logic                 r4_valid;
    t_op                  r4_op;
    logic                 r4_tdeg;
    logic signed [NW-1:0] r4_tn [3];
    logic signed [SW-1:0] r4_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= w_tag1[T1W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_op   <= t_op'(w_tag1[1:0]);
            r4_tdeg <= w_deg1[0];
            r4_tn   <= w_n1[0];
            for (int c = 0; c < 3; c++) begin
                r4_s[c] <= SW'(w_n1[0][c]) + SW'(w_n1[1][c])
                         + SW'(w_n1[2][c]) + SW'(w_n1[3][c]);
            end
        end
    end

    logic signed [NW-1:0] w_n2 [3];
    logic                 w_deg2;
    logic [T2W-1:0]       w_tag2;

    tqfn_norm #(
        .W  (SW),
        .F  (F),
        .TW (T2W)
    ) u_norm_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r4_s),
        .i_tag   ({r4_valid, r4_op, r4_tdeg, r4_tn[0], r4_tn[1], r4_tn[2]}),
        .o_n     (w_n2),
        .o_degen (w_deg2),
        .o_tag   (w_tag2)
    );

    logic                 w_t2_valid;
    t_op                  w_t2_op;
    logic                 w_t2_tdeg;
    logic signed [NW-1:0] w_t2_tn [3];
    logic signed [OW-1:0] w_sel [3];
    logic                 w_sel_deg;
    t_out_item            w_res;

    assign w_t2_valid = w_tag2[T2W-1];
    assign w_t2_op    = t_op'(w_tag2[T2W-2 -: 2]);
    assign w_t2_tdeg  = w_tag2[3*NW];
    assign w_t2_tn[0] = w_tag2[3*NW-1 -: NW];
    assign w_t2_tn[1] = w_tag2[2*NW-1 -: NW];
    assign w_t2_tn[2] = w_tag2[NW-1:0];

    always_comb begin
        unique case (w_t2_op)
            OP_QUAD: begin
                for (int c = 0; c < 3; c++) begin
                    w_sel[c] = OW'(w_n2[c]);
                end
                w_sel_deg = w_deg2;
            end
            OP_TRI: begin
                for (int c = 0; c < 3; c++) begin
                    w_sel[c] = OW'(w_t2_tn[c]);
                end
                w_sel_deg = w_t2_tdeg;
            end
            OP_ZERO, OP_WRITE: begin
                for (int c = 0; c < 3; c++) begin
                    w_sel[c] = '0;
                end
                w_sel_deg = 1'b0;
            end
        endcase
    end

    assign w_res.normal_x   = w_sel[0][NRM_W-1:0];
    assign w_res.normal_y   = w_sel[1][NRM_W-1:0];
    assign w_res.normal_z   = w_sel[2][NRM_W-1:0];
    assign w_res.degenerate = w_sel_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_t2_valid && (w_t2_op != OP_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/tqfn_checker.sv
// Port-level assertions for the face normal core, bound to the top level.
`default_nettype none

module tqfn_checker import tqfn_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled result changed or vanished.");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.degenerate |->
            o_out_item.normal_x == '0 && o_out_item.normal_y == '0 &&
            o_out_item.normal_z == '0)
        else $error("Degenerate result carries a nonzero normal.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset left a result or a stall behind.");

endmodule

bind triangle_quad_face_normal_core tqfn_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
